// ----- hw/rtl/three_voice_wavetable_synth_assert.svh -----
// Assertion macros used by the wavetable synth top level.
`ifndef THREE_VOICE_WAVETABLE_SYNTH_ASSERT_SVH
`define THREE_VOICE_WAVETABLE_SYNTH_ASSERT_SVH

// Condition that holds on every cycle out of reset.
`define TVWS_ASSERT_ALWAYS(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Same-cycle implication.
`define TVWS_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define TVWS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hw/rtl/tvws_pkg.sv -----
// Shared types and constants for the three-voice wavetable synth.
package tvws_pkg;

  localparam int NumVoices   = 3;
  localparam int WaveEntries = 256;
  localparam int AccWidth    = 20;
  localparam int WaveAddrW   = $clog2(WaveEntries);
  localparam int VolScaledW  = 11;

  localparam logic [VolScaledW-1:0] VolScale   = 11'd85;
  localparam logic signed [8:0]     WaveOffset = 9'sd8;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_TICK  = 2'd2,
    OP_LOAD  = 2'd3
  } opcode_t;

  typedef enum logic {
    KIND_READ   = 1'b0,
    KIND_SAMPLE = 1'b1
  } kind_t;

  typedef struct packed {
    opcode_t    opcode;
    logic [7:0] addr;
    logic [7:0] data;
  } cmd_t;

  typedef struct packed {
    kind_t              kind;
    logic [3:0]         read_data;
    logic signed [15:0] sample;
  } res_t;

  // Voice bank view handed to stage 2 and the wave store read.
  typedef struct packed {
    logic [3:0]                                 read_data;
    logic [NumVoices-1:0][WaveAddrW-1:0]        wave_addr;
    logic [NumVoices-1:0][VolScaledW-1:0]       vol_scaled;
  } bank_out_t;

endpackage

// ----- hw/rtl/tvws_voice_bank.sv -----
// Voice register file: bus decode, nibble read/write, accumulator stepping.
module tvws_voice_bank import tvws_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  cmd_t      cmd,
  output bank_out_t bank
);

  typedef enum logic [4:0] {
    SEL_NONE = 5'b00001,
    SEL_ACC  = 5'b00010,
    SEL_FREQ = 5'b00100,
    SEL_WAVE = 5'b01000,
    SEL_VOL  = 5'b10000
  } sel_t;

  typedef struct packed {
    sel_t                sel;
    logic [1:0]          voice;
    logic [2:0]          nib;
    logic [AccWidth-1:0] keep;
  } slot_t;

  function automatic slot_t decode(input logic [7:0] addr);
    slot_t      s;
    logic [3:0] low;
    logic       hi;
    logic [3:0] off;
    s     = '{sel: SEL_NONE, voice: 2'd0, nib: 3'd0, keep: '0};
    low   = addr[3:0];
    hi    = addr[4];
    off   = '0;
    if (addr[7:5] == 3'd0) begin
      if (low < 4'd6) begin
        s.voice = 2'd0;
        off     = low;
        if (off == 4'd5) begin
          s.sel = hi ? SEL_VOL : SEL_WAVE;
        end else begin
          s.sel  = hi ? SEL_FREQ : SEL_ACC;
          s.nib  = off[2:0];
          s.keep = 20'hfffff & ~(20'hf << {s.nib, 2'b00});
        end
      end else begin
        s.voice = (low < 4'd11) ? 2'd1 : 2'd2;
        off     = low - ((low < 4'd11) ? 4'd6 : 4'd11);
        if (off == 4'd4) begin
          s.sel = hi ? SEL_VOL : SEL_WAVE;
        end else if (hi) begin
          s.sel  = SEL_FREQ;
          s.nib  = off[2:0] + 3'd1;
          s.keep = 20'hffff0 & ~(20'hf << {s.nib, 2'b00});
        end else begin
          s.sel  = SEL_ACC;
          s.nib  = off[2:0];
          s.keep = 20'h0ffff & ~(20'hf << {s.nib, 2'b00});
        end
      end
    end
    return s;
  endfunction

  logic [NumVoices-1:0][AccWidth-1:0] phase_acc, phase_acc_next;
  logic [NumVoices-1:0][AccWidth-1:0] freq_word, freq_word_next;
  logic [NumVoices-1:0][2:0]          wave_select, wave_select_next;
  logic [NumVoices-1:0][3:0]          voice_volume, voice_volume_next;

  logic [NumVoices-1:0][AccWidth-1:0] stepped;
  logic [NumVoices-1:0]               active;
  logic [AccWidth-1:0]                wr_nib;
  slot_t                              slot;

  assign slot   = decode(cmd.addr);
  assign wr_nib = AccWidth'(cmd.data[3:0]) << {slot.nib, 2'b00};

  always_comb begin
    for (int v = 0; v < NumVoices; v++) begin
      active[v]          = (|freq_word[v]) && (|voice_volume[v]);
      stepped[v]         = phase_acc[v] + freq_word[v];
      bank.wave_addr[v]  = {wave_select[v], stepped[v][AccWidth-1 -: 5]};
      bank.vol_scaled[v] = active[v] ? VolScaledW'(voice_volume[v]) * VolScale : '0;
    end
    unique case (slot.sel)
      SEL_ACC:  bank.read_data = 4'(phase_acc[slot.voice] >> {slot.nib, 2'b00});
      SEL_FREQ: bank.read_data = 4'(freq_word[slot.voice] >> {slot.nib, 2'b00});
      SEL_WAVE: bank.read_data = {1'b0, wave_select[slot.voice]};
      SEL_VOL:  bank.read_data = voice_volume[slot.voice];
      default:  bank.read_data = 4'd0;
    endcase
  end

  always_comb begin
    phase_acc_next    = phase_acc;
    freq_word_next    = freq_word;
    wave_select_next  = wave_select;
    voice_volume_next = voice_volume;
    if (fire) begin
      unique case (cmd.opcode)
        OP_WRITE: begin
          unique case (slot.sel)
            SEL_ACC:  phase_acc_next[slot.voice] =
                        (phase_acc[slot.voice] & slot.keep) | wr_nib;
            SEL_FREQ: freq_word_next[slot.voice] =
                        (freq_word[slot.voice] & slot.keep) | wr_nib;
            SEL_WAVE: wave_select_next[slot.voice]  = cmd.data[2:0];
            SEL_VOL:  voice_volume_next[slot.voice] = cmd.data[3:0];
            default: ;
          endcase
        end
        OP_TICK: begin
          for (int v = 0; v < NumVoices; v++) begin
            if (active[v]) begin
              phase_acc_next[v] = stepped[v];
            end
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase_acc    <= '0;
      freq_word    <= '0;
      wave_select  <= '0;
      voice_volume <= '0;
    end else begin
      phase_acc    <= phase_acc_next;
      freq_word    <= freq_word_next;
      wave_select  <= wave_select_next;
      voice_volume <= voice_volume_next;
    end
  end

endmodule

// ----- hw/rtl/three_voice_wavetable_synth.sv -----
// Top level of the three-voice wavetable synth: pipeline, wave store, mixer.
//
// Usage:
//   cmd channel (cmd_valid/cmd_ready/cmd) carries one bus transaction per
//   cycle: register read, register write, sample tick or wave store load.
//   res channel (res_valid/res_ready/res) returns one transaction for each
//   read (kind KIND_READ) and each tick (kind KIND_SAMPLE); writes and
//   loads return nothing.
//   A result passes through the input register, then the voice bank /
//   wave store read into stage 2, then the mixer into the result register.
//   Throughput: one command per cycle while the receiver takes results,
//   set by the register update of the voice bank and one wave store read
//   port per voice.
//   When the receiver stalls, the result, stage 2 and input registers still
//   fill, so up to three reads or ticks are taken before cmd_ready drops;
//   writes and loads keep flowing until a read or tick waits in the input.
//   Reset clears all voice registers and pipeline valids; the wave store
//   is not cleared and must be loaded before a tick reads an entry.
`include "three_voice_wavetable_synth_assert.svh"

module three_voice_wavetable_synth import tvws_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_ready,
  output res_t res
);

  logic      s1_valid;
  cmd_t      s1_cmd;
  logic      s1_result;
  logic      s1_fire;

  logic                                  s2_valid;
  kind_t                                 s2_kind;
  logic [3:0]                            s2_read_data;
  logic [NumVoices-1:0][VolScaledW-1:0]  s2_vol_scaled;
  logic [7:0]                            wave_q [NumVoices];
  logic                                  s2_ready;

  logic                                  out_open;
  bank_out_t                             bank;

  logic [7:0]         wave_mem [NumVoices][WaveEntries];
  logic signed [8:0]  wave_delta [NumVoices];
  logic signed [20:0] term [NumVoices];
  logic [15:0]        mix;

  assign out_open  = !res_valid || res_ready;
  assign s2_ready  = !s2_valid || out_open;
  assign s1_result = (s1_cmd.opcode == OP_READ) || (s1_cmd.opcode == OP_TICK);
  assign s1_fire   = s1_valid && (!s1_result || s2_ready);
  assign cmd_ready = !s1_valid || s1_fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (cmd_ready) begin
      s1_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_ready && cmd_valid) begin
      s1_cmd <= cmd;
    end
  end

  tvws_voice_bank u_bank (
    .clk  (clk),
    .rst  (rst),
    .fire (s1_fire),
    .cmd  (s1_cmd),
    .bank (bank)
  );

  // One copy of the wave store per voice so each tick reads three entries.
  for (genvar v = 0; v < NumVoices; v++) begin : g_wave
    always_ff @(posedge clk) begin
      if (s1_fire && s1_cmd.opcode == OP_LOAD) begin
        wave_mem[v][s1_cmd.addr] <= s1_cmd.data;
      end
      if (s1_fire && s1_cmd.opcode == OP_TICK) begin
        wave_q[v] <= wave_mem[v][bank.wave_addr[v]];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s2_ready) begin
      s2_valid <= s1_fire && s1_result;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_result) begin
      s2_kind       <= (s1_cmd.opcode == OP_TICK) ? KIND_SAMPLE : KIND_READ;
      s2_read_data  <= bank.read_data;
      s2_vol_scaled <= bank.vol_scaled;
    end
  end

  // Silent voices may fetch unloaded entries; they stay out of the sum.
  always_comb begin
    mix = '0;
    for (int v = 0; v < NumVoices; v++) begin
      wave_delta[v] = $signed({1'b0, wave_q[v]}) - WaveOffset;
      term[v]       = wave_delta[v] * $signed({1'b0, s2_vol_scaled[v]});
      if (s2_vol_scaled[v] != '0) begin
        mix = mix + term[v][15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_open) begin
      res_valid <= s2_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_open && s2_valid) begin
      res.kind <= s2_kind;
      if (s2_kind == KIND_SAMPLE) begin
        res.read_data <= 4'd0;
        res.sample    <= $signed(mix);
      end else begin
        res.read_data <= s2_read_data;
        res.sample    <= 16'sd0;
      end
    end
  end

  `TVWS_ASSERT_IMPLY(a_input_open, !s1_valid, cmd_ready, "input stage empty but not ready")
  `TVWS_ASSERT_NEXT(a_result_staged, s1_fire && s1_result, s2_valid, "result lost after stage 1")
  `TVWS_ASSERT_NEXT(a_s2_hold, s2_valid && !s2_ready, s2_valid && $stable(s2_kind), "stage 2 dropped")
  `TVWS_ASSERT_ALWAYS(a_read_clean, !(res_valid && res.kind == KIND_READ) || res.sample == 16'sd0, "read result carries sample")

endmodule
